/* hdl/mcf_pkg.sv */
// ----------------------------------------------------------------------------
// Motor command framer package
// Shared types, codes and the CRC-7 update function for the framer.
// ----------------------------------------------------------------------------
package mcf_pkg;

  // Action codes carried in the request.
  localparam logic [2:0] ACT_EXIT_SAFE_START = 3'd0;
  localparam logic [2:0] ACT_FORWARD         = 3'd1;
  localparam logic [2:0] ACT_REVERSE         = 3'd2;
  localparam logic [2:0] ACT_BRAKE           = 3'd3;
  localparam logic [2:0] ACT_GET_VARIABLE    = 3'd4;
  localparam logic [2:0] ACT_STOP            = 3'd5;
  localparam logic [2:0] ACT_REPLY_BYTE      = 3'd6;
  localparam logic [2:0] ACT_UNUSED          = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_BYTE   = 3'd0;
  localparam logic [2:0] CFG_OP_EXIT_SAFE = 3'd1;
  localparam logic [2:0] CFG_OP_FORWARD   = 3'd2;
  localparam logic [2:0] CFG_OP_REVERSE   = 3'd3;
  localparam logic [2:0] CFG_OP_BRAKE     = 3'd4;
  localparam logic [2:0] CFG_OP_GET_VAR   = 3'd5;
  localparam logic [2:0] CFG_OP_STOP      = 3'd6;
  localparam logic [2:0] CFG_LINK_ENABLE  = 3'd7;

  localparam logic [7:0] CRC7_POLY = 8'h91;
  localparam int         MAX_BYTES = 5;    // packet bytes before the CRC byte
  localparam int         QUEUE_DEPTH = 4;
  localparam int         QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  device_number;
    logic [11:0] amount;
    logic [7:0]  variable_id;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_reply;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] reply_value;
    logic        crc_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [6:0] op_exit_safe_start;
    logic [6:0] op_forward;
    logic [6:0] op_reverse;
    logic [6:0] op_brake;
    logic [6:0] op_get_variable;
    logic [6:0] op_stop;
    logic       link_enable;
  } cfg_t;

  // One unit of work for the back end: a packet to serialize or a finished reply.
  typedef struct packed {
    logic                      is_reply;
    logic [2:0]                len;
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [15:0]               reply_value;
    logic                      crc_error;
  } job_t;

  // Reflected CRC-7 over one byte, eight bit steps.
  function automatic logic [6:0] crc7_update(input logic [6:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = {1'b0, crc} ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = v ^ CRC7_POLY;
      end
      v = v >> 1;
    end
    return v[6:0];
  endfunction

endpackage

/* hdl/mcf_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO that decouples the command front end from the serializer.
// ----------------------------------------------------------------------------
module mcf_queue import mcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_job,
  input  logic  pop,
  output job_t  head,
  output logic  full,
  output logic  empty
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* hdl/mcf_front.sv */
// ----------------------------------------------------------------------------
// Command front end
// Accepts requests, builds packet jobs from commands and collects reply bytes.
// ----------------------------------------------------------------------------
module mcf_front import mcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  in_item_t cmd_item,
  input  logic     queue_full,
  output logic     push,
  output job_t     push_job
);

  logic [1:0] reply_count;
  logic [6:0] reply_crc;
  logic [7:0] reply_low;
  logic [7:0] reply_high;
  logic       accept;
  logic       is_cmd;
  logic       bad;

  assign cmd_stall = queue_full;
  assign accept    = cmd_valid && !queue_full;
  assign is_cmd    = (cmd_item.action != ACT_REPLY_BYTE) && (cmd_item.action != ACT_UNUSED);
  assign bad       = (cmd_item.rx_byte != {1'b0, reply_crc});

  always_comb begin
    push_job             = '0;
    push_job.bytes[0]    = cfg.start_byte;
    push_job.bytes[1]    = {1'b0, cmd_item.device_number};
    push                 = 1'b0;
    case (cmd_item.action)
      ACT_EXIT_SAFE_START: begin
        push_job.bytes[2] = {1'b0, cfg.op_exit_safe_start};
        push_job.len      = 3'd3;
      end
      ACT_FORWARD, ACT_REVERSE: begin
        push_job.bytes[2] = (cmd_item.action == ACT_FORWARD) ? {1'b0, cfg.op_forward}
                                                              : {1'b0, cfg.op_reverse};
        push_job.bytes[3] = {3'b000, cmd_item.amount[4:0]};
        push_job.bytes[4] = {1'b0, cmd_item.amount[11:5]};
        push_job.len      = 3'd5;
      end
      ACT_BRAKE: begin
        push_job.bytes[2] = {1'b0, cfg.op_brake};
        push_job.bytes[3] = (cmd_item.amount[11:8] != 4'd0) ? 8'hFF : cmd_item.amount[7:0];
        push_job.len      = 3'd4;
      end
      ACT_GET_VARIABLE: begin
        push_job.bytes[2] = {1'b0, cfg.op_get_variable};
        push_job.bytes[3] = cmd_item.variable_id;
        push_job.len      = 3'd4;
      end
      ACT_STOP: begin
        push_job.bytes[2] = {1'b0, cfg.op_stop};
        push_job.len      = 3'd3;
      end
      ACT_REPLY_BYTE: begin
        push_job.is_reply    = 1'b1;
        push_job.crc_error   = bad;
        push_job.reply_value = bad ? 16'd0 : {reply_high, reply_low};
      end
      default: begin
        push_job.len = 3'd3;
      end
    endcase
    if (accept) begin
      if (is_cmd) begin
        push = cfg.link_enable;
      end else if (cmd_item.action == ACT_REPLY_BYTE) begin
        push = (reply_count == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count <= '0;
      reply_crc   <= '0;
      reply_low   <= '0;
      reply_high  <= '0;
    end else if (accept) begin
      if (cmd_item.action == ACT_REPLY_BYTE) begin
        case (reply_count)
          2'd0: begin
            reply_low   <= cmd_item.rx_byte;
            reply_crc   <= crc7_update(7'd0, cmd_item.rx_byte);
            reply_count <= 2'd1;
          end
          2'd1: begin
            reply_high  <= cmd_item.rx_byte;
            reply_crc   <= crc7_update(reply_crc, cmd_item.rx_byte);
            reply_count <= 2'd2;
          end
          default: begin
            reply_crc   <= '0;
            reply_count <= 2'd0;
          end
        endcase
      end else if (cmd_item.action == ACT_GET_VARIABLE && cfg.link_enable) begin
        // A new get-variable request on an enabled link drops any partly collected reply.
        reply_crc   <= '0;
        reply_count <= 2'd0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) reply_count != 2'd3)
    else $error("reply count out of range");
  a_reply_push: assert property (@(posedge clk) disable iff (rst)
      push && push_job.is_reply |=> reply_count == 2'd0)
    else $error("reply state not cleared after reply result");
  a_cmd_push_len: assert property (@(posedge clk) disable iff (rst)
      push && !push_job.is_reply |-> push_job.len >= 3'd3 && push_job.len <= 3'd5)
    else $error("packet job with bad length");

endmodule

/* hdl/mcf_back.sv */
// ----------------------------------------------------------------------------
// Packet serializer
// Takes jobs from the queue and emits one result per cycle unless res_stall holds it, appending CRC-7 to packets.
// ----------------------------------------------------------------------------
module mcf_back import mcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic [2:0] idx;
  logic [2:0] idx_next;
  logic [6:0] crc;
  logic [6:0] crc_next;
  logic       load;
  out_item_t  item_next;

  assign load = !empty && (!res_valid || !res_stall);

  always_comb begin
    item_next = '0;
    idx_next  = idx;
    crc_next  = crc;
    pop       = 1'b0;
    if (head.is_reply) begin
      item_next.is_reply    = 1'b1;
      item_next.reply_value = head.reply_value;
      item_next.crc_error   = head.crc_error;
      pop                   = load;
    end else if (idx == head.len) begin
      item_next.tx_byte = {1'b0, crc};
      item_next.last    = 1'b1;
      pop               = load;
      idx_next          = '0;
      crc_next          = '0;
    end else begin
      item_next.tx_byte = head.bytes[idx];
      idx_next          = idx + 1'b1;
      crc_next          = crc7_update(crc, head.bytes[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= '0;
      res_valid <= 1'b0;
    end else if (load) begin
      idx       <= idx_next;
      crc       <= crc_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item <= item_next;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
      !empty && !head.is_reply |-> idx <= head.len)
    else $error("byte index past packet length");
  a_last_not_reply: assert property (@(posedge clk) disable iff (rst)
      res_valid && res_item.last |-> !res_item.is_reply)
    else $error("last flag on a reply result");
  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
      res_valid && res_item.crc_error |-> res_item.reply_value == 16'd0)
    else $error("reply value not cleared on CRC error");
  a_idle_between: assert property (@(posedge clk) disable iff (rst)
      pop && !head.is_reply |=> idx == 3'd0 && crc == 7'd0)
    else $error("serializer state not cleared after packet");

endmodule

/* hdl/motor_command_framer_crc7_top.sv */
// ----------------------------------------------------------------------------
// Motor command framer with CRC-7
// Frames motor controller commands into serial packets and checks replies.
// ----------------------------------------------------------------------------
// A command packet of n bytes (start, device, opcode, arguments) leaves as n+1
// results, one per clock on the result channel while res_stall is low, the last
// being the CRC-7 byte; a reply byte is taken as one request and the third one
// of a reply yields a single result. The output register of the serializer sets
// this pace. The front end takes a request every cycle while the 4-entry job
// queue has room, so requests that make no result and reply bytes pass while
// earlier packets are still being sent.
module motor_command_framer_crc7_top import mcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  in_item_t  cmd_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item,
  input  logic      cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  cfg_t cfg;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte         <= 8'd170;
      cfg.op_exit_safe_start <= 7'd3;
      cfg.op_forward         <= 7'd5;
      cfg.op_reverse         <= 7'd6;
      cfg.op_brake           <= 7'd18;
      cfg.op_get_variable    <= 7'd33;
      cfg.op_stop            <= 7'd96;
      cfg.link_enable        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_BYTE:   cfg.start_byte         <= cfg_wdata;
        CFG_OP_EXIT_SAFE: cfg.op_exit_safe_start <= cfg_wdata[6:0];
        CFG_OP_FORWARD:   cfg.op_forward         <= cfg_wdata[6:0];
        CFG_OP_REVERSE:   cfg.op_reverse         <= cfg_wdata[6:0];
        CFG_OP_BRAKE:     cfg.op_brake           <= cfg_wdata[6:0];
        CFG_OP_GET_VAR:   cfg.op_get_variable    <= cfg_wdata[6:0];
        CFG_OP_STOP:      cfg.op_stop            <= cfg_wdata[6:0];
        CFG_LINK_ENABLE:  cfg.link_enable        <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  mcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  mcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  mcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule
